// File: rtl/core/cwas_pkg.sv
// ----------------------------------------------------------------------------
// Common window package
// Shared request types, field widths and control structs for the common
// window block.
// ----------------------------------------------------------------------------
package cwas_pkg;

  localparam int VALUE_W = 16;
  localparam int KLEN_W  = 11;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;
  localparam logic [KLEN_W-1:0]  KLEN_RESET = 11'd4;

  localparam logic OP_FIRST = 1'b0;
  localparam logic OP_LATER = 1'b1;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic               common_exists;
    logic [COUNT_W-1:0] alive_count;
    logic               too_long;
  } out_req_t;

  typedef struct packed {
    logic store;
    logic clear;
    logic clr_runs;
    logic set_alive;
    logic step;
    logic scan;
    logic kill;
  } dp_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit_v;
    logic hit;
  } dp_st_t;

endpackage

// File: rtl/core/cwas_dp.sv
// ----------------------------------------------------------------------------
// Common window datapath
// Holds the reference words, the run counters and the found and alive bits,
// and runs the pipelined per-position match update and the end-of-sequence
// survival scan, one position per cycle.
// ----------------------------------------------------------------------------
module cwas_dp #(
  parameter int MAX_LEN = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cwas_pkg::dp_ctl_t               ctl_i,
  input  logic [$clog2(MAX_LEN)-1:0]      addr_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]    len_i,
  input  logic [cwas_pkg::KLEN_W-1:0]     klen_i,
  input  logic [cwas_pkg::VALUE_W-1:0]    value_i,
  output cwas_pkg::dp_st_t                st_o
);
  import cwas_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int CW = ((PW > KLEN_W) ? PW : KLEN_W) + 1;

  logic [VALUE_W-1:0] word_mem_q  [MAX_LEN];
  logic [PW-1:0]      fwd_mem_q   [MAX_LEN];
  logic [PW-1:0]      rev_mem_q   [MAX_LEN];
  logic               ffnd_mem_q  [MAX_LEN];
  logic               rfnd_mem_q  [MAX_LEN];
  logic               alive_mem_q [MAX_LEN];

  logic               rd_v_q;
  logic [AW-1:0]      rd_a_q;
  logic [VALUE_W-1:0] rd_word_q;
  logic [PW-1:0]      rd_fwd_q;
  logic [PW-1:0]      rd_rev_q;

  logic               cur_v_q;
  logic [AW-1:0]      cur_a_q;
  logic [VALUE_W-1:0] cur_word_q;
  logic [PW-1:0]      cur_fwd_q;
  logic [PW-1:0]      carry_q;

  logic               sc_v_q;
  logic [AW-1:0]      sc_a_q;
  logic               sc_kill_q;
  logic               sc_alive_q;
  logic               sc_ff_q;
  logic               sc_rf_q;

  logic [CW-1:0]      k_ext;
  logic [CW-1:0]      pos_ext;
  logic [CW-1:0]      ff_ext;
  logic [AW-1:0]      ff_addr;
  logic               has_next;
  logic               match;
  logic [PW-1:0]      prev_run;
  logic [PW-1:0]      next_run;
  logic [PW-1:0]      fwd_new;
  logic [PW-1:0]      rev_new;
  logic               ff_hit;
  logic               rf_hit;
  logic               sc_new;

  function automatic logic [CW-1:0] run_next(logic [CW-1:0] prev, logic [CW-1:0] k);
    logic [CW-1:0] sum;
    sum = prev + CW'(1);
    return (sum >= k) ? k : sum;
  endfunction

  always_comb begin
    k_ext    = CW'(klen_i);
    pos_ext  = CW'(cur_a_q) + CW'(1);
    ff_ext   = pos_ext - k_ext;
    ff_addr  = ff_ext[AW-1:0];
    has_next = pos_ext < CW'(len_i);
    match    = (cur_word_q == value_i);
    prev_run = (cur_a_q == '0) ? '0 : carry_q;
    next_run = (rd_v_q && has_next) ? rd_rev_q : '0;
    fwd_new  = match ? PW'(run_next(CW'(prev_run), k_ext)) : '0;
    rev_new  = match ? PW'(run_next(CW'(next_run), k_ext)) : '0;
    ff_hit   = cur_v_q && (CW'(fwd_new) >= k_ext);
    rf_hit   = cur_v_q && (CW'(rev_new) >= k_ext);
    sc_new   = sc_alive_q & (~sc_kill_q | sc_ff_q | sc_rf_q);
  end

  assign st_o.busy  = rd_v_q | cur_v_q | sc_v_q;
  assign st_o.hit_v = sc_v_q;
  assign st_o.hit   = sc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      cur_v_q <= 1'b0;
      sc_v_q  <= 1'b0;
    end else begin
      rd_v_q  <= ctl_i.step;
      cur_v_q <= rd_v_q;
      sc_v_q  <= ctl_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q     <= addr_i;
    rd_word_q  <= word_mem_q[addr_i];
    rd_fwd_q   <= fwd_mem_q[addr_i];
    rd_rev_q   <= rev_mem_q[addr_i];
    sc_a_q     <= addr_i;
    sc_kill_q  <= ctl_i.kill;
    sc_alive_q <= alive_mem_q[addr_i];
    sc_ff_q    <= ffnd_mem_q[addr_i];
    sc_rf_q    <= rfnd_mem_q[addr_i];
    if (rd_v_q) begin
      cur_a_q    <= rd_a_q;
      cur_word_q <= rd_word_q;
      cur_fwd_q  <= rd_fwd_q;
    end
    if (cur_v_q) begin
      carry_q <= cur_fwd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.store) begin
      word_mem_q[addr_i] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear && ctl_i.clr_runs) begin
      fwd_mem_q[addr_i] <= '0;
      rev_mem_q[addr_i] <= '0;
    end else if (cur_v_q) begin
      fwd_mem_q[cur_a_q] <= fwd_new;
      rev_mem_q[cur_a_q] <= rev_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear && ctl_i.clr_runs) begin
      ffnd_mem_q[addr_i] <= 1'b0;
    end else if (ff_hit) begin
      ffnd_mem_q[ff_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear && ctl_i.clr_runs) begin
      rfnd_mem_q[addr_i] <= 1'b0;
    end else if (rf_hit) begin
      rfnd_mem_q[cur_a_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear && ctl_i.set_alive) begin
      alive_mem_q[addr_i] <= 1'b1;
    end else if (sc_v_q && sc_kill_q) begin
      alive_mem_q[sc_a_q] <= sc_new;
    end
  end

endmodule

// File: rtl/core/common_window_across_sequences.sv
// ----------------------------------------------------------------------------
// Common window across sequences
// Loads a reference sequence, then checks each later sequence for every
// reference window, read forward or reversed, and reports the survivors.
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_stall_o  in_req_i  (op, value, last)
// out       out  out_valid_o/out_stall_i out_req_o (common_exists, alive_count,
//                                                  too_long)
// cfg       in   cfg_valid_i/cfg_ready_o cfg_window_len_i
//
// After reset an initialization pass over every position runs with in_stall_o high.
// A word that starts a sequence adds a clearing pass over every position.
// A later-sequence word steps the match update over the run counter memory,
// one position per cycle across the N positions of the reference sequence.
// A reference word is stored in the word memory; a last word adds the survival
// scan over every window start, and waits while a previous result is stalled.
// ----------------------------------------------------------------------------
module common_window_across_sequences #(
  parameter int MAX_LEN = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cwas_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cwas_pkg::out_req_t          out_req_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cwas_pkg::KLEN_W-1:0] cfg_window_len_i
);
  import cwas_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int CW = ((PW > KLEN_W) ? PW : KLEN_W) + 1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WORK,
    ST_STEP,
    ST_STEP_WAIT,
    ST_END,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [PW-1:0]      len_q, len_d;
  logic               ovf_q, ovf_d;
  logic [KLEN_W-1:0]  klen_q, klen_d;
  in_req_t            req_q, req_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  out_req_t           out_q, out_d;

  logic [KLEN_W-1:0]  k_eff;
  logic [CW-1:0]      k_ext;
  logic [CW-1:0]      scan_lim;
  logic               full;
  dp_ctl_t            dp_ctl;
  dp_st_t             dp_st;
  logic [AW-1:0]      dp_addr;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign cfg_ready_o = 1'b1;

  assign k_eff    = (klen_q == '0) ? KLEN_W'(1) : klen_q;
  assign k_ext    = CW'(k_eff);
  assign scan_lim = CW'(len_q) - k_ext;
  assign full     = (pos_q == PW'(MAX_LEN));

  always_comb begin
    dp_ctl.store     = (state_q == ST_WORK) && !full && (req_q.op == OP_FIRST);
    dp_ctl.clear     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    dp_ctl.clr_runs  = (state_q == ST_INIT) || (req_q.op == OP_LATER);
    dp_ctl.set_alive = (state_q == ST_INIT) || (req_q.op == OP_FIRST);
    dp_ctl.step      = (state_q == ST_STEP);
    dp_ctl.scan      = (state_q == ST_SCAN);
    dp_ctl.kill      = (req_q.op == OP_LATER);
    dp_addr          = (state_q == ST_WORK) ? pos_q[AW-1:0] : idx_q;
  end

  cwas_dp #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dp_ctl),
    .addr_i (dp_addr),
    .len_i  (len_q),
    .klen_i (k_eff),
    .value_i(req_q.value),
    .st_o   (dp_st)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    klen_d      = klen_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_valid_i) begin
      klen_d = cfg_window_len_i;
    end
    if (dp_st.hit_v && dp_st.hit && (cnt_q != COUNT_MAX)) begin
      cnt_d = cnt_q + COUNT_W'(1);
    end

    case (state_q)
      ST_INIT: begin
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(MAX_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          idx_d = '0;
          if (pos_q == '0) begin
            state_d = ST_CLEAR;
            if (in_req_i.op == OP_FIRST) begin
              len_d = '0;
            end
          end else begin
            state_d = ST_WORK;
          end
        end
      end
      ST_CLEAR: begin
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(MAX_LEN - 1)) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        idx_d = '0;
        if (full) begin
          ovf_d   = 1'b1;
          state_d = ST_END;
        end else if (req_q.op == OP_FIRST) begin
          len_d   = pos_q + PW'(1);
          pos_d   = pos_q + PW'(1);
          state_d = ST_END;
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = (len_q == '0) ? ST_END : ST_STEP;
        end
      end
      ST_STEP: begin
        idx_d = idx_q + AW'(1);
        if (PW'(idx_q) == len_q - PW'(1)) begin
          state_d = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        if (!dp_st.busy) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        idx_d = '0;
        if (!req_q.last) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d   = '0;
          state_d = (k_ext <= CW'(len_q)) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + AW'(1);
        if (CW'(idx_q) == scan_lim) begin
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        if (!dp_st.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.common_exists = (cnt_q != '0);
          out_d.alive_count   = cnt_q;
          out_d.too_long      = ovf_q;
          pos_d               = '0;
          ovf_d               = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      klen_q      <= KLEN_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      klen_q      <= klen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_LEN))
    else $error("sequence position beyond capacity");

  a_end_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_END |-> !dp_st.busy)
    else $error("match pipeline still busy at word end");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the report state");

  a_scan_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> k_ext <= CW'(len_q))
    else $error("survival scan with a window longer than the reference");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> CW'(cnt_q) <= CW'(len_q))
    else $error("alive count exceeds reference length");

endmodule
